// ===== design/tdxseg_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and state codes of the track dE/dx segmenter.
package tdxseg_pkg;

   // Hit store depth
   localparam int MAX_HITS   = 64;
   localparam int HIT_CNT_W  = $clog2(MAX_HITS + 1);
   localparam int ADDR_W     = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

   // Field widths
   localparam int ENERGY_W   = 16;
   localparam int LEN_W      = 16;
   localparam int RANGE_W    = 22;
   localparam int QUOT_W     = 16;
   localparam int LEN_FRAC   = 10;
   localparam int HI_SHIFT   = QUOT_W - LEN_FRAC;
   localparam int HIT_W      = ENERGY_W + LEN_W;

   // Accumulator widths follow from the store depth
   localparam int SUM_GROW   = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int ESUM_W     = ENERGY_W + SUM_GROW;
   localparam int EPOS_W     = ESUM_W - 1;
   localparam int LSUM_W     = LEN_W + SUM_GROW;
   localparam int CMP_W      = ((LSUM_W > RANGE_W) ? LSUM_W : RANGE_W) + 1;
   localparam int MID_W      = CMP_W - 1;
   localparam int SAT_W      = (EPOS_W > LSUM_W + HI_SHIFT) ? EPOS_W : LSUM_W + HI_SHIFT;
   localparam int STEP_W     = $clog2(QUOT_W + 1);

   localparam logic [QUOT_W-1:0]  QUOT_MAX  = '1;
   localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 22;
   localparam logic [CSR_IDX_W-1:0] CSR_WALK_FORWARD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEG_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE    = 2'd2;

   localparam logic               WALK_FORWARD_RST = 1'b1;
   localparam logic [LEN_W-1:0]   MIN_SEG_LEN_RST  = 16'd1024;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RST    = 22'd307200;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_ACC,
      ST_CLOSE,
      ST_DIV,
      ST_EMIT,
      ST_FIN
   } seg_state_type;

   typedef struct packed {
      logic              start;
      logic [EPOS_W-1:0] dividend;
      logic [LSUM_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== design/tdxseg_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module tdxseg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== design/tdxseg_div.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider for energy over length, saturating quotient.
module tdxseg_div (
   input  logic                        clock,
   input  logic                        reset,
   input  tdxseg_pkg::div_req_type     div_req,
   output logic                        div_done,
   output logic [tdxseg_pkg::QUOT_W-1:0] div_quot
);
   import tdxseg_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LSUM_W-1:0] rem_ff, rem_in;
   logic [LSUM_W-1:0] dsr_ff, dsr_in;
   logic [QUOT_W-1:0] low_ff, low_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [LSUM_W:0]   rem_sh;
   logic [LSUM_W:0]   rem_sub;
   logic              fits;
   logic              sat;

   // quotient reaches 2^16 exactly when dividend >= divisor * 64
   assign sat = SAT_W'(div_req.dividend) >= (SAT_W'(div_req.divisor) << HI_SHIFT);

   assign rem_sh  = {rem_ff, low_ff[QUOT_W-1]};
   assign fits    = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         dsr_in = div_req.divisor;
         rem_in = LSUM_W'(div_req.dividend >> HI_SHIFT);
         low_in = {div_req.dividend[HI_SHIFT-1:0], {LEN_FRAC{1'b0}}};
         step_in = '0;
         if (sat) begin
            quot_in = QUOT_MAX;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[LSUM_W-1:0] : rem_sh[LSUM_W-1:0];
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         low_in  = {low_ff[QUOT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign div_done = done_ff;
   assign div_quot = quot_ff;

endmodule

// ===== design/track_dedx_segmenter.sv =====
`timescale 1ns / 1ps
// Top level of the track dE/dx segmenter: hit store, walk sequencer, divider, result register.
//
// Hits of one track load one per cycle into a 64-entry hit RAM; hits past the
// store depth are dropped and flagged on every result of the track. The item
// with last_hit starts the walk, and no new hit is taken until the walk ends.
// The walk reads one stored hit per cycle from the RAM (registered read), and
// each segment walked also passes through ST_READ and ST_CLOSE. Each segment
// that is emitted then waits in a shared restoring divider (sixteen quotient
// bits, one per cycle, then the done flag), or only for the done flag when
// the quotient saturates, and is handed off in ST_EMIT. Results leave through
// an output register, one item per segment; the final item of a track carries
// last_segment, and a track that emits no segment gives one item with
// segment_valid low.
module track_dedx_segmenter (
   input  logic                                clock,
   input  logic                                reset,
   // hit input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tdxseg_pkg::ENERGY_W-1:0] req_hit_energy,
   input  logic [tdxseg_pkg::LEN_W-1:0]        req_hit_length,
   input  logic [tdxseg_pkg::RANGE_W-1:0]      req_start_distance,
   input  logic                                req_last_hit,
   // segment output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_segment_valid,
   output logic [tdxseg_pkg::QUOT_W-1:0]       rsp_energy_per_length,
   output logic [tdxseg_pkg::RANGE_W-1:0]      rsp_range_midpoint,
   output logic                                rsp_hits_dropped,
   output logic                                rsp_last_segment,
   // configuration
   input  logic                                csr_we,
   input  logic [tdxseg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdxseg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tdxseg_pkg::*;

   // configuration registers
   logic               walk_fwd_ff;
   logic [LEN_W-1:0]   min_seg_ff;
   logic [RANGE_W-1:0] max_range_ff;

   // track state
   seg_state_type         state_ff, state_in;
   logic [HIT_CNT_W-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [RANGE_W-1:0]    fd_ff, fd_in;
   logic                  ovf_ff, ovf_in;
   logic [HIT_CNT_W-1:0]  k_ff, k_in;
   logic signed [ESUM_W-1:0] esum_ff, esum_in;
   logic [LSUM_W-1:0]     lsum_ff, lsum_in;
   logic [LSUM_W-1:0]     r1_ff, r1_in;
   logic                  more_ff, more_in;
   logic [RANGE_W-1:0]    mid_ff, mid_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [QUOT_W-1:0]     pend_q_ff, pend_q_in;
   logic [RANGE_W-1:0]    pend_mid_ff, pend_mid_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_seg_ff, rsp_seg_in;
   logic [QUOT_W-1:0]     rsp_q_ff, rsp_q_in;
   logic [RANGE_W-1:0]    rsp_mid_ff, rsp_mid_in;
   logic                  rsp_drop_ff, rsp_drop_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_load;
   logic                  slot_free;

   // memory and divider
   logic                  ram_we;
   logic                  ram_re;
   logic [HIT_CNT_W-1:0]  k_rd;
   logic [HIT_CNT_W-1:0]  rd_idx;
   logic [HIT_W-1:0]      ram_rd_data;
   logic [ENERGY_W-1:0]   rd_energy;
   logic [LEN_W-1:0]      rd_length;
   div_req_type           div_req;
   logic                  div_start;
   logic                  div_done;
   logic [QUOT_W-1:0]     div_quot;

   // segment close arithmetic: twice the midpoint is r0 + r1
   logic [CMP_W-1:0]      twice_mid;
   logic [CMP_W-1:0]      twice_max;
   logic [MID_W-1:0]      mid_full;
   logic [RANGE_W-1:0]    mid_sat;

   assign twice_mid = CMP_W'({r1_ff, 1'b0}) + CMP_W'(lsum_ff);
   assign twice_max = CMP_W'({max_range_ff, 1'b0});
   assign mid_full  = twice_mid[CMP_W-1:1];
   assign mid_sat   = (mid_full > MID_W'(RANGE_MAX)) ? RANGE_MAX : mid_full[RANGE_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rd_energy = ram_rd_data[HIT_W-1:LEN_W];
   assign rd_length = ram_rd_data[LEN_W-1:0];
   assign rd_idx    = walk_fwd_ff ? k_rd : (hit_cnt_ff - HIT_CNT_W'(1) - k_rd);

   assign div_req.start    = div_start;
   assign div_req.dividend = esum_ff[EPOS_W-1:0];
   assign div_req.divisor  = lsum_ff;

   tdxseg_ram #(
      .WIDTH (HIT_W),
      .DEPTH (MAX_HITS)
   ) u_hit_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hit_cnt_ff[ADDR_W-1:0]),
      .wr_data ({req_hit_energy, req_hit_length}),
      .rd_en   (ram_re),
      .rd_addr (rd_idx[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   tdxseg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_fwd_ff  <= WALK_FORWARD_RST;
         min_seg_ff   <= MIN_SEG_LEN_RST;
         max_range_ff <= MAX_RANGE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WALK_FORWARD: walk_fwd_ff  <= csr_wdata[0];
            CSR_MIN_SEG_LEN:  min_seg_ff   <= csr_wdata[LEN_W-1:0];
            CSR_MAX_RANGE:    max_range_ff <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      hit_cnt_in    = hit_cnt_ff;
      fd_in         = fd_ff;
      ovf_in        = ovf_ff;
      k_in          = k_ff;
      esum_in       = esum_ff;
      lsum_in       = lsum_ff;
      r1_in         = r1_ff;
      more_in       = more_ff;
      mid_in        = mid_ff;
      pend_valid_in = pend_valid_ff;
      pend_q_in     = pend_q_ff;
      pend_mid_in   = pend_mid_ff;
      rsp_load      = 1'b0;
      rsp_seg_in    = rsp_seg_ff;
      rsp_q_in      = rsp_q_ff;
      rsp_mid_in    = rsp_mid_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      k_rd          = k_ff;
      div_start     = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (hit_cnt_ff == '0 && !ovf_ff) begin
                  fd_in = req_start_distance;
               end
               if (hit_cnt_ff < HIT_CNT_W'(MAX_HITS)) begin
                  ram_we     = 1'b1;
                  hit_cnt_in = hit_cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_hit) begin
                  k_in          = '0;
                  r1_in         = '0;
                  pend_valid_in = 1'b0;
                  more_in       = fd_in < max_range_ff;
                  state_in      = ST_READ;
               end
            end
         end
         ST_READ: begin
            esum_in = '0;
            lsum_in = '0;
            if (k_ff < hit_cnt_ff && more_ff) begin
               ram_re   = 1'b1;
               state_in = ST_ACC;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ACC: begin
            esum_in = esum_ff + {{(ESUM_W - ENERGY_W){rd_energy[ENERGY_W-1]}}, rd_energy};
            lsum_in = lsum_ff + LSUM_W'(rd_length);
            k_in    = k_ff + 1'b1;
            k_rd    = k_in;
            // prefetch the next hit while the segment stays open
            if (k_in < hit_cnt_ff && lsum_in <= LSUM_W'(min_seg_ff)) begin
               ram_re = 1'b1;
            end else begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE: begin
            r1_in   = r1_ff + lsum_ff;
            more_in = twice_mid < twice_max;
            mid_in  = mid_sat;
            if (!esum_ff[ESUM_W-1] && esum_ff != '0 && lsum_ff != '0 && more_in) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold the newest segment back until we know whether it is the last
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_load    = 1'b1;
                  rsp_seg_in  = 1'b1;
                  rsp_q_in    = pend_q_ff;
                  rsp_mid_in  = pend_mid_ff;
                  rsp_drop_in = ovf_ff;
                  rsp_last_in = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_q_in     = div_quot;
               pend_mid_in   = mid_ff;
               state_in      = ST_READ;
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_seg_in  = pend_valid_ff;
               rsp_q_in    = pend_valid_ff ? pend_q_ff : '0;
               rsp_mid_in  = pend_valid_ff ? pend_mid_ff : '0;
               rsp_drop_in = ovf_ff;
               rsp_last_in = 1'b1;
               hit_cnt_in  = '0;
               fd_in       = '0;
               ovf_in      = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         hit_cnt_ff    <= '0;
         fd_ff         <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hit_cnt_ff    <= hit_cnt_in;
         fd_ff         <= fd_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      k_ff        <= k_in;
      esum_ff     <= esum_in;
      lsum_ff     <= lsum_in;
      r1_ff       <= r1_in;
      more_ff     <= more_in;
      mid_ff      <= mid_in;
      pend_q_ff   <= pend_q_in;
      pend_mid_ff <= pend_mid_in;
      if (rsp_load) begin
         rsp_seg_ff  <= rsp_seg_in;
         rsp_q_ff    <= rsp_q_in;
         rsp_mid_ff  <= rsp_mid_in;
         rsp_drop_ff <= rsp_drop_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_segment_valid     = rsp_seg_ff;
   assign rsp_energy_per_length = rsp_q_ff;
   assign rsp_range_midpoint    = rsp_mid_ff;
   assign rsp_hits_dropped      = rsp_drop_ff;
   assign rsp_last_segment      = rsp_last_ff;

endmodule

// ===== design/tdxseg_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the track dE/dx segmenter, bound to its top level.
module tdxseg_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_last_hit,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_segment_valid,
   input logic [tdxseg_pkg::QUOT_W-1:0]     rsp_energy_per_length,
   input logic [tdxseg_pkg::RANGE_W-1:0]    rsp_range_midpoint,
   input logic                              rsp_hits_dropped,
   input logic                              rsp_last_segment
);

   // output register comes up empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment_valid)
         && $stable(rsp_energy_per_length) && $stable(rsp_range_midpoint)
         && $stable(rsp_hits_dropped) && $stable(rsp_last_segment))
      else $error("stalled result changed");

   // the empty-track marker is the only item of its track and carries zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_segment_valid |->
         rsp_last_segment && rsp_energy_per_length == '0 && rsp_range_midpoint == '0)
      else $error("malformed empty-track marker");

   // the walk blocks new hits right after the last hit of a track
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_hit |=> !req_ready)
      else $error("hit accepted while walking a track");

endmodule

bind track_dedx_segmenter tdxseg_checker u_tdxseg_checker (.*);
